FILE: src/ckd_pkg.sv
package ckd_pkg;

    // key count and bus widths
    localparam int NUM_KEYS  = 7;
    localparam int KEY_BUS_W = ((NUM_KEYS + 7) / 8) * 8;

    localparam logic [NUM_KEYS-1:0] KEY_ALL_RELEASED = {NUM_KEYS{1'b1}};

    // repeat timer codes
    localparam logic [7:0] REP_READY   = 8'd0;
    localparam logic [7:0] REP_SENT    = 8'd1;
    localparam logic [7:0] REP_TIMEOUT = 8'd2;

    // configuration reset values
    localparam logic [7:0] DEBOUNCE_MS_RESET  = 8'd10;
    localparam logic [7:0] HOLD_TICKS_RESET   = 8'd33;
    localparam logic       EARLY_DETECT_RESET = 1'b1;

    // input item kinds
    typedef enum logic [1:0] {
        FUNC_SAMPLE = 2'd0,
        FUNC_MS     = 2'd1,
        FUNC_REPEAT = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_DEBOUNCE_MS  = 2'd0,
        CFG_HOLD_TICKS   = 2'd1,
        CFG_EARLY_DETECT = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [7:0] debounce_ms;
        logic [7:0] hold_ticks;
        logic       early_detect;
    } cfg_t;

    typedef struct packed {
        func_t               func;
        logic [NUM_KEYS-1:0] keys;
    } item_t;

    typedef struct packed {
        logic                valid;
        logic [NUM_KEYS-1:0] chord;
        logic                on_hold;
    } result_t;

endpackage

FILE: src/ckd_in_reg.sv
module ckd_in_reg (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  ckd_pkg::item_t in_item,
    input  logic          advance,
    output logic          item_valid,
    output ckd_pkg::item_t item
);
    import ckd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // take a new request when empty or when the held one moves on
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload holds no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: src/ckd_engine.sv
module ckd_engine (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  ckd_pkg::item_t  item,
    input  ckd_pkg::cfg_t   cfg,
    output ckd_pkg::result_t result
);
    import ckd_pkg::*;

    logic [NUM_KEYS-1:0] last_sample_reg,  last_sample_next;
    logic [7:0]          debounce_reg,     debounce_next;
    logic [NUM_KEYS-1:0] latched_reg,      latched_next;
    logic                adding_reg,       adding_next;
    logic [7:0]          repeat_reg,       repeat_next;

    logic [NUM_KEYS-1:0] d;
    logic                press;
    logic                release_any;
    logic                fire;

    assign d           = item.keys;
    assign press       = |(latched_reg & ~d);
    assign release_any = |(~latched_reg & d);
    assign fire        = cfg.early_detect ? adding_reg : (d == KEY_ALL_RELEASED);

    // one item updates the chord state and may produce one result
    always_comb
    begin
        last_sample_next = last_sample_reg;
        debounce_next    = debounce_reg;
        latched_next     = latched_reg;
        adding_next      = adding_reg;
        repeat_next      = repeat_reg;
        result.valid     = 1'b0;
        result.chord     = ~latched_reg;
        result.on_hold   = 1'b0;

        unique case (item.func)
            FUNC_SAMPLE:
            begin
                if (d != last_sample_reg)
                begin
                    if (debounce_reg == 8'd0)
                    begin
                        debounce_next = cfg.debounce_ms;
                    end
                    else if (debounce_reg == 8'd1)
                    begin
                        // debounced change accepted
                        last_sample_next = d;
                        debounce_next    = 8'd0;
                        if (press)
                        begin
                            adding_next  = 1'b1;
                            latched_next = latched_reg & d;
                            repeat_next  = cfg.hold_ticks;
                        end
                        else if (release_any)
                        begin
                            if (fire)
                            begin
                                result.valid = (repeat_reg != REP_SENT);
                                latched_next = d;
                                adding_next  = 1'b0;
                            end
                            repeat_next = REP_READY;
                            if (cfg.early_detect)
                            begin
                                latched_next = d;
                            end
                        end
                    end
                end
                else if (repeat_reg == REP_TIMEOUT)
                begin
                    // hold timeout reports once
                    result.valid   = adding_reg;
                    result.on_hold = 1'b1;
                    repeat_next    = REP_SENT;
                end
            end
            FUNC_MS:
            begin
                if (debounce_reg > 8'd1)
                begin
                    debounce_next = debounce_reg - 8'd1;
                end
            end
            FUNC_REPEAT:
            begin
                if (repeat_reg > REP_TIMEOUT)
                begin
                    repeat_next = repeat_reg - 8'd1;
                end
            end
            default:
            begin
            end
        endcase

        if (!step)
        begin
            result.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_sample_reg <= KEY_ALL_RELEASED;
            debounce_reg    <= 8'd0;
            latched_reg     <= KEY_ALL_RELEASED;
            adding_reg      <= 1'b0;
            repeat_reg      <= REP_READY;
        end
        else if (step)
        begin
            last_sample_reg <= last_sample_next;
            debounce_reg    <= debounce_next;
            latched_reg     <= latched_next;
            adding_reg      <= adding_next;
            repeat_reg      <= repeat_next;
        end
    end

endmodule

FILE: src/ckd_out_reg.sv
module ckd_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  ckd_pkg::result_t result,
    output logic             space,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [ckd_pkg::NUM_KEYS-1:0] out_chord,
    output logic             out_on_hold
);
    import ckd_pkg::*;

    logic                valid_reg;
    logic                valid_next;
    logic [NUM_KEYS-1:0] chord_reg;
    logic                on_hold_reg;

    // room for a new result when empty or being taken
    assign space = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (step)
        begin
            valid_next = result.valid;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && result.valid)
        begin
            chord_reg   <= result.chord;
            on_hold_reg <= result.on_hold;
        end
    end

    assign out_valid   = valid_reg;
    assign out_chord   = chord_reg;
    assign out_on_hold = on_hold_reg;

endmodule

FILE: src/chord_key_detector.sv
// Chord key detector: debounces seven active-low keys, latches every key
// pressed during a chord and reports the chord (pressed keys as ones) on
// release, on the first release or on full release as early_detect selects,
// or once with the hold flag when a chord is held until the repeat timer
// expires. An input request carries its kind in s_tuser (0 key sample,
// 1 millisecond tick, 2 repeat tick, 3 ignored) and the key levels in
// s_tdata. The block takes one request every clock cycle while the result
// register has room or the master side accepts; each request is held in
// the input register and its result is registered in the result register
// before it appears on the master side. Requests that cause no result
// produce nothing on the master side. Configuration writes are taken at any
// time and are meant for when the block is idle.
module chord_key_detector (
    input  logic                          clk,
    input  logic                          rst_n,
    // key requests
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [ckd_pkg::KEY_BUS_W-1:0] s_tdata,   // [6:0] keys, rest zero
    input  logic [1:0]                    s_tuser,   // [1:0] func
    // chord results
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ckd_pkg::KEY_BUS_W-1:0] m_tdata,   // [6:0] chord, rest zero
    output logic                          m_tuser,   // [0] on_hold
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_index,
    input  logic [7:0]                    cfg_data
);
    import ckd_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    item_t   in_item;
    item_t   item;
    result_t result;
    logic    item_valid;
    logic    space;
    logic    step;
    logic [NUM_KEYS-1:0] out_chord;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DEBOUNCE_MS:  cfg_next.debounce_ms  = cfg_data;
                CFG_HOLD_TICKS:   cfg_next.hold_ticks   = cfg_data;
                CFG_EARLY_DETECT: cfg_next.early_detect = cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms  <= DEBOUNCE_MS_RESET;
            cfg_reg.hold_ticks   <= HOLD_TICKS_RESET;
            cfg_reg.early_detect <= EARLY_DETECT_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // unpack the request
    assign in_item.func = func_t'(s_tuser);
    assign in_item.keys = s_tdata[NUM_KEYS-1:0];

    // an item moves on when the result register has room
    assign step = item_valid && space;

    ckd_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (step),
        .item_valid (item_valid),
        .item       (item)
    );

    ckd_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item),
        .cfg    (cfg_reg),
        .result (result)
    );

    ckd_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .result      (result),
        .space       (space),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_chord   (out_chord),
        .out_on_hold (m_tuser)
    );

    assign m_tdata = {{(KEY_BUS_W-NUM_KEYS){1'b0}}, out_chord};

endmodule
